[rtl/core/jcls_pkg.sv]
// package for the joint command limiter and smoother
// types, command codes and reset constants; no dependencies
package jcls_pkg;

   localparam int JOINTS_DEF = 20;
   localparam logic [15:0] ALPHA_RST = 16'd983;
   localparam logic [9:0] MIN_INTERVAL_RST = 10'd20;
   localparam logic signed [15:0] HW_LOW_RST = -16'sd32768;
   localparam logic signed [15:0] HW_HIGH_RST = 16'sd32767;

   localparam logic [2:0] CMD_SET_JOINT = 3'd0;
   localparam logic [2:0] CMD_SET_USER = 3'd1;
   localparam logic [2:0] CMD_RESET_USER = 3'd2;
   localparam logic [2:0] CMD_TICK = 3'd3;
   localparam logic [2:0] CMD_LOAD_HW = 3'd4;

   localparam logic [0:0] CSR_ALPHA = 1'd0;
   localparam logic [0:0] CSR_MIN_INTERVAL = 1'd1;

   typedef struct packed {
      logic [2:0] cmd;
      logic [4:0] joint;
      logic signed [15:0] value;
      logic signed [15:0] limit_low;
      logic signed [15:0] limit_high;
      logic [31:0] time_ms;
   } req_word_type;

   typedef struct packed {
      logic [4:0] joint_out;
      logic signed [15:0] position;
      logic is_position;
      logic rejected;
      logic range_violation;
      logic too_soon;
      logic last;
      logic [15:0] processed_count;
      logic [15:0] dropped_count;
      logic [15:0] violation_count;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request word
      logic rd;        // issue read of joint at index
      logic exec;      // perform command on read data
      logic emit;      // result into output register
      logic [4:0] idx;
      logic tick_last;
   } ctl_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

   function automatic logic signed [15:0] lim(input logic signed [15:0] v,
         input logic signed [15:0] lo, input logic signed [15:0] hi);
      logic signed [15:0] r;
      r = v;
      if (lo <= hi) begin
         if (v < lo) r = lo;
         else if (v > hi) r = hi;
      end
      return r;
   endfunction

endpackage

[rtl/core/joint_command_limiter_smoother_unit.sv]
// top level of the joint command limiter and smoother
// joins jcls_ctrl and jcls_dp; uses jcls_pkg
//
// channel  dir  handshake             payload
// req      in   req_valid/req_stall   req_word_type
// rsp      out  rsp_valid/rsp_stall   rsp_word_type
// csr      in   csr_write             csr_index, csr_data
//
// a command runs through capture, per-joint register read, execute and emit
// a tick repeats read, execute and emit for each joint through the shared filter
// synchronous reset; no clearing pass, the limit stores use valid bits
// a stalled result holds the sequencer in its emit step
module joint_command_limiter_smoother_unit import jcls_pkg::*; #(
   parameter int JOINTS = JOINTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_word_type req_word,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_word_type rsp_word,
   input  logic csr_write,
   input  logic [0:0] csr_index,
   input  logic [15:0] csr_data
);
   ctl_type ctl;
   sts_type sts;

   jcls_ctrl #(.JOINTS(JOINTS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall,
      .req_cmd(req_word.cmd), .req_joint(req_word.joint), .sts, .ctl
   );

   jcls_dp #(.JOINTS(JOINTS)) u_dp (
      .clock, .reset, .ctl, .sts, .req_word,
      .csr_write, .csr_index, .csr_data, .rsp_valid, .rsp_stall, .rsp_word
   );
endmodule

[rtl/core/jcls_ctrl.sv]
// controller state machine for the joint command limiter
// sequences reads, execution and result emission; uses jcls_pkg
module jcls_ctrl import jcls_pkg::*; #(
   parameter int JOINTS = JOINTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_cmd,
   input  logic [4:0] req_joint,
   input  sts_type sts,
   output ctl_type ctl
);
   localparam logic [4:0] LAST_IDX = 5'(JOINTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EXEC = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] idx_ff, idx_in;
   logic tick_ff, tick_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      tick_in = tick_ff;
      ctl = '0;
      ctl.idx = idx_ff;
      ctl.tick_last = tick_ff && (idx_ff == LAST_IDX);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               tick_in = (req_cmd == CMD_TICK);
               idx_in = (req_cmd == CMD_TICK) ? 5'd0 : req_joint;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ctl.rd = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.out_busy) begin
               ctl.emit = 1'b1;
               if (tick_ff && idx_ff != LAST_IDX) begin
                  idx_in = idx_ff + 5'd1;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         tick_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         tick_ff <= tick_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> state_ff == ST_EMIT)
      else $error("emit outside emit state");
   assert property (@(posedge clock) disable iff (reset)
      tick_ff && state_ff != ST_IDLE |-> idx_ff <= LAST_IDX)
      else $error("tick index out of range");
   assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> state_ff == ST_READ)
      else $error("load did not start read");
endmodule

[rtl/core/jcls_dp.sv]
// datapath for the joint command limiter: per-joint stores, filter, counters
// driven by jcls_ctrl commands; uses jcls_pkg
module jcls_dp import jcls_pkg::*; #(
   parameter int JOINTS = JOINTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  ctl_type ctl,
   output sts_type sts,
   input  req_word_type req_word,
   input  logic csr_write,
   input  logic [0:0] csr_index,
   input  logic [15:0] csr_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_word_type rsp_word
);
   localparam int IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   logic [15:0] alpha_ff;
   logic [9:0] mint_ff;
   req_word_type q_ff;

   logic signed [15:0] hw_low_ff [JOINTS];
   logic signed [15:0] hw_high_ff [JOINTS];
   logic [JOINTS-1:0] hw_set_ff, use_user_ff, pending_ff;
   logic signed [15:0] user_low_ff [JOINTS];
   logic signed [15:0] user_high_ff [JOINTS];
   logic signed [15:0] pval_ff [JOINTS];
   logic [31:0] ltime_ff [JOINTS];
   logic signed [15:0] target_ff [JOINTS];
   logic signed [31:0] filt_ff [JOINTS];
   logic [JOINTS-1:0] tf_set_ff;

   // registered per-joint read
   logic signed [15:0] rd_hwl_ff, rd_hwh_ff, rd_ul_ff, rd_uh_ff, rd_pv_ff, rd_tg_ff;
   logic signed [31:0] rd_f_ff;
   logic [31:0] rd_lt_ff;
   logic rd_use_ff, rd_pend_ff, rd_ok_ff;

   logic [15:0] proc_ff, drop_ff, viol_ff;
   rsp_word_type res_ff, res_in;
   logic valid_ff;

   logic [IW-1:0] ai;
   logic ok;
   assign ok = (32'(ctl.idx) < 32'(JOINTS));
   assign ai = IW'(ctl.idx);

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         rd_ok_ff <= ok;
         rd_hwl_ff <= hw_set_ff[ai] ? hw_low_ff[ai] : HW_LOW_RST;
         rd_hwh_ff <= hw_set_ff[ai] ? hw_high_ff[ai] : HW_HIGH_RST;
         rd_ul_ff <= user_low_ff[ai];
         rd_uh_ff <= user_high_ff[ai];
         rd_use_ff <= use_user_ff[ai];
         rd_pend_ff <= pending_ff[ai];
         rd_pv_ff <= pval_ff[ai];
         rd_lt_ff <= ltime_ff[ai];
         rd_tg_ff <= tf_set_ff[ai] ? target_ff[ai] : 16'sd0;
         rd_f_ff <= tf_set_ff[ai] ? filt_ff[ai] : 32'sd0;
      end
   end

   // execute stage: combinational filter arithmetic, results registered on exec
   logic signed [15:0] elo, ehi, ntg, pos;
   logic signed [33:0] d;
   logic signed [50:0] prod;
   logic signed [49:0] nf;
   logic signed [31:0] nfs;
   logic signed [15:0] ul_c, uh_c;
   logic [31:0] dt;
   logic ts, rv, set_ok;
   assign elo = rd_use_ff ? rd_ul_ff : rd_hwl_ff;
   assign ehi = rd_use_ff ? rd_uh_ff : rd_hwh_ff;
   assign ntg = rd_pend_ff ? lim(rd_pv_ff, elo, ehi) : rd_tg_ff;
   assign d = 34'(ntg) * 34'sd65536 - 34'(rd_f_ff);
   assign prod = $signed({1'b0, alpha_ff}) * d;
   assign nf = 50'(rd_f_ff) + 50'(prod >>> 16);
   assign nfs = (nf > 50'sd2147483647) ? 32'sh7fffffff :
                (nf < -50'sd2147483648) ? 32'sh80000000 : 32'(nf);
   assign pos = lim(16'(nfs >>> 16), elo, ehi);
   assign ul_c = lim(q_ff.limit_low, rd_hwl_ff, rd_hwh_ff);
   assign uh_c = lim(q_ff.limit_high, rd_hwl_ff, rd_hwh_ff);
   assign dt = q_ff.time_ms - rd_lt_ff;
   assign ts = rd_pend_ff && (dt < 32'(mint_ff));
   assign rv = (q_ff.value < rd_hwl_ff) || (q_ff.value > rd_hwh_ff);
   assign set_ok = q_ff.limit_low < q_ff.limit_high;

   function automatic logic [15:0] sat_inc(input logic [15:0] c, input logic en);
      return (en && c != 16'hffff) ? c + 16'd1 : c;
   endfunction

   rsp_word_type pend_ff, pend_in;
   logic [IW-1:0] xi;
   assign xi = IW'(ctl.idx);

   always_comb begin
      pend_in = '0;
      pend_in.joint_out = ctl.idx;
      pend_in.last = (q_ff.cmd != CMD_TICK) || ctl.tick_last;
      case (q_ff.cmd)
         CMD_TICK: begin
            pend_in.is_position = 1'b1;
            pend_in.position = pos;
         end
         CMD_SET_JOINT: begin
            if (rd_ok_ff) begin
               pend_in.range_violation = rv;
               pend_in.too_soon = ts;
            end else pend_in.rejected = 1'b1;
         end
         CMD_SET_USER: pend_in.rejected = !(rd_ok_ff && set_ok);
         CMD_LOAD_HW: pend_in.rejected = !rd_ok_ff;
         CMD_RESET_USER: ;
         default: pend_in.rejected = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) q_ff <= req_word;
      if (ctl.exec) begin
         pend_ff <= pend_in;
         case (q_ff.cmd)
            CMD_TICK: begin
               target_ff[xi] <= ntg;
               filt_ff[xi] <= nfs;
            end
            CMD_SET_JOINT: begin
               if (rd_ok_ff) begin
                  pval_ff[xi] <= q_ff.value;
                  ltime_ff[xi] <= q_ff.time_ms;
               end
            end
            CMD_SET_USER: begin
               if (rd_ok_ff && set_ok) begin
                  user_low_ff[xi] <= ul_c;
                  user_high_ff[xi] <= uh_c;
               end
            end
            CMD_LOAD_HW: begin
               if (rd_ok_ff) begin
                  hw_low_ff[xi] <= q_ff.limit_low;
                  hw_high_ff[xi] <= q_ff.limit_high;
               end
            end
            default: ;
         endcase
      end
   end

   // control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RST;
         mint_ff <= MIN_INTERVAL_RST;
         hw_set_ff <= '0;
         use_user_ff <= '0;
         pending_ff <= '0;
         tf_set_ff <= '0;
         proc_ff <= '0;
         drop_ff <= '0;
         viol_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == CSR_ALPHA) alpha_ff <= csr_data;
         if (csr_write && csr_index == CSR_MIN_INTERVAL) mint_ff <= csr_data[9:0];
         if (ctl.exec) begin
            case (q_ff.cmd)
               CMD_TICK: begin
                  pending_ff[xi] <= 1'b0;
                  tf_set_ff[xi] <= 1'b1;
               end
               CMD_SET_JOINT: begin
                  if (rd_ok_ff) begin
                     pending_ff[xi] <= 1'b1;
                     proc_ff <= sat_inc(proc_ff, 1'b1);
                     drop_ff <= sat_inc(drop_ff, ts);
                     viol_ff <= sat_inc(viol_ff, rv);
                  end
               end
               CMD_SET_USER: if (rd_ok_ff && set_ok) use_user_ff[xi] <= 1'b1;
               CMD_LOAD_HW: if (rd_ok_ff) hw_set_ff[xi] <= 1'b1;
               CMD_RESET_USER: use_user_ff <= '0;
               default: ;
            endcase
         end
         if (ctl.emit) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
      end
   end

   always_comb begin
      res_in = pend_ff;
      res_in.processed_count = proc_ff;
      res_in.dropped_count = drop_ff;
      res_in.violation_count = viol_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) res_ff <= res_in;
   end

   assign sts.out_busy = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_word = res_ff;

   assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> !(valid_ff && rsp_stall))
      else $error("result overwritten while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.is_position |-> !rsp_word.rejected)
      else $error("position result marked rejected");
   assert property (@(posedge clock) disable iff (reset)
      ctl.exec |=> !ctl.exec)
      else $error("back to back execute");
endmodule

[test/testbench.sv]
// self-checking testbench for joint_command_limiter_smoother_unit
// drives a directed command table and random traffic, predicts every result word
// depends on jcls_pkg and the unit under test only
module testbench import jcls_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NJ = JOINTS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
   localparam logic [2:0] CMD_BAD_LAST = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_write = 1'b0;
   logic [0:0] csr_index = CSR_ALPHA;
   logic [15:0] csr_data = '0;

   always #5 clock = ~clock;

   joint_command_limiter_smoother_unit u_top (.*);

   // predictor state
   logic [15:0] p_alpha;
   logic [9:0] p_min_ivl;
   logic signed [15:0] hw_lo[NJ], hw_hi[NJ], usr_lo[NJ], usr_hi[NJ], pend_val[NJ], tgt[NJ];
   logic signed [31:0] filt[NJ];
   logic [31:0] last_ms[NJ];
   logic use_usr[NJ], pend[NJ];
   logic [15:0] n_proc, n_drop, n_viol;

   rsp_word_type expected_words[$];
   int errors = 0;
   int idle_cycles = 0;

   function automatic logic signed [15:0] clampv(logic signed [15:0] v,
         logic signed [15:0] lo, logic signed [15:0] hi);
      if (lo > hi) return v;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic signed [63:0] floor16(logic signed [63:0] p);
      return p >>> 16;
   endfunction

   function automatic logic [15:0] sat_inc(logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   task automatic predictor_reset();
      p_alpha = ALPHA_RST;
      p_min_ivl = MIN_INTERVAL_RST;
      for (int i = 0; i < NJ; i++) begin
         hw_lo[i] = HW_LOW_RST; hw_hi[i] = HW_HIGH_RST;
         usr_lo[i] = '0; usr_hi[i] = '0; use_usr[i] = 1'b0;
         pend[i] = 1'b0; pend_val[i] = '0; last_ms[i] = '0; tgt[i] = '0; filt[i] = '0;
      end
      n_proc = '0; n_drop = '0; n_viol = '0;
   endtask

   function automatic rsp_word_type ack_word(logic [4:0] j, logic rej, logic rv, logic ts);
      rsp_word_type r;
      r = '0;
      r.joint_out = j; r.rejected = rej; r.range_violation = rv; r.too_soon = ts;
      r.last = 1'b1;
      r.processed_count = n_proc; r.dropped_count = n_drop; r.violation_count = n_viol;
      return r;
   endfunction

   task automatic predict_command(req_word_type w);
      logic ok;
      logic ts, rv;
      logic signed [15:0] elo, ehi, pos;
      logic signed [63:0] d, nf;
      rsp_word_type r;
      ok = w.joint < NJ;
      case (w.cmd)
         CMD_TICK: begin
            for (int i = 0; i < NJ; i++) begin
               elo = use_usr[i] ? usr_lo[i] : hw_lo[i];
               ehi = use_usr[i] ? usr_hi[i] : hw_hi[i];
               if (pend[i]) begin
                  tgt[i] = clampv(pend_val[i], elo, ehi);
                  pend[i] = 1'b0;
               end
               d = (64'(tgt[i]) <<< 16) - 64'(filt[i]);
               nf = 64'(filt[i]) + floor16($signed({48'd0, p_alpha}) * d);
               if (nf > 64'sd2147483647) nf = 64'sd2147483647;
               if (nf < -64'sd2147483648) nf = -64'sd2147483648;
               filt[i] = nf[31:0];
               pos = clampv(filt[i][31:16], elo, ehi);
               r = ack_word(5'(i), 1'b0, 1'b0, 1'b0);
               r.position = pos; r.is_position = 1'b1; r.last = (i == NJ - 1);
               expected_words.push_back(r);
            end
         end
         CMD_SET_JOINT: begin
            if (!ok) expected_words.push_back(ack_word(w.joint, 1'b1, 1'b0, 1'b0));
            else begin
               ts = pend[w.joint] && ((w.time_ms - last_ms[w.joint]) < {22'd0, p_min_ivl});
               rv = (w.value < hw_lo[w.joint]) || (w.value > hw_hi[w.joint]);
               if (ts) n_drop = sat_inc(n_drop);
               if (rv) n_viol = sat_inc(n_viol);
               pend_val[w.joint] = w.value; pend[w.joint] = 1'b1;
               last_ms[w.joint] = w.time_ms;
               n_proc = sat_inc(n_proc);
               expected_words.push_back(ack_word(w.joint, 1'b0, rv, ts));
            end
         end
         CMD_SET_USER: begin
            if (!ok || !(w.limit_low < w.limit_high))
               expected_words.push_back(ack_word(w.joint, 1'b1, 1'b0, 1'b0));
            else begin
               usr_lo[w.joint] = clampv(w.limit_low, hw_lo[w.joint], hw_hi[w.joint]);
               usr_hi[w.joint] = clampv(w.limit_high, hw_lo[w.joint], hw_hi[w.joint]);
               use_usr[w.joint] = 1'b1;
               expected_words.push_back(ack_word(w.joint, 1'b0, 1'b0, 1'b0));
            end
         end
         CMD_RESET_USER: begin
            for (int i = 0; i < NJ; i++) use_usr[i] = 1'b0;
            expected_words.push_back(ack_word(w.joint, 1'b0, 1'b0, 1'b0));
         end
         CMD_LOAD_HW: begin
            if (!ok) expected_words.push_back(ack_word(w.joint, 1'b1, 1'b0, 1'b0));
            else begin
               hw_lo[w.joint] = w.limit_low; hw_hi[w.joint] = w.limit_high;
               expected_words.push_back(ack_word(w.joint, 1'b0, 1'b0, 1'b0));
            end
         end
         default: expected_words.push_back(ack_word(w.joint, 1'b1, 1'b0, 1'b0));
      endcase
   endtask

   // receiver: stalls on its own pattern, checks every word
   int stall_mode = 0;
   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t unexpected word, actual %p", $time, rsp_word);
            end else begin
               e = expected_words.pop_front();
               if (rsp_word !== e) begin
                  errors++;
                  $display("%0t mismatch: expected %p actual %p", $time, e, rsp_word);
               end
            end
         end
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   int burst_left = 0;

   // valid stays high inside a burst and drops only for a gap or a drain
   task automatic send_word(req_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_command(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (NJ * 3 + 10) @(posedge clock);
   endtask

   task automatic csr_set(logic [0:0] idx, logic [15:0] data);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_ALPHA) p_alpha = data;
      else p_min_ivl = data[9:0];
   endtask

   function automatic req_word_type mk(logic [2:0] c, int j, int v, int lo, int hi,
         logic [31:0] t);
      req_word_type w;
      w.cmd = c; w.joint = 5'(j); w.value = 16'(v);
      w.limit_low = 16'(lo); w.limit_high = 16'(hi); w.time_ms = t;
      return w;
   endfunction

   // rows whose acknowledgement is rejected by inspection
   function automatic logic known_reject(req_word_type w);
      if (w.cmd >= CMD_BAD_FIRST) return 1'b1;
      if (w.cmd == CMD_TICK || w.cmd == CMD_RESET_USER) return 1'b0;
      return w.joint >= NJ;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int k;
      w = '0;
      w.joint = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(NJ, 31))
                                           : 5'($urandom_range(0, NJ - 1));
      w.value = 16'($urandom); w.limit_low = 16'($urandom); w.limit_high = 16'($urandom);
      w.time_ms = $urandom;
      if ($urandom_range(0, 1) == 0) begin
         w.value = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
         w.limit_low = -16'sd8192 + $signed(16'($urandom_range(0, 4000)));
         w.limit_high = 16'sd8192 - $signed(16'($urandom_range(0, 4000)));
      end
      k = $urandom_range(0, 99);
      if (k < 40) w.cmd = CMD_SET_JOINT;
      else if (k < 55) w.cmd = CMD_TICK;
      else if (k < 75) w.cmd = CMD_SET_USER;
      else if (k < 82) w.cmd = CMD_RESET_USER;
      else if (k < 95) w.cmd = CMD_LOAD_HW;
      else w.cmd = 3'($urandom_range(int'(CMD_BAD_FIRST), int'(CMD_BAD_LAST)));
      if (w.cmd == CMD_SET_JOINT && w.joint < NJ) begin
         w.time_ms = ($urandom_range(0, 1) == 0) ? last_ms[w.joint] + $urandom_range(0, 40)
                                               : $urandom;
      end
      return w;
   endfunction

   req_word_type directed[$];

   initial begin
      req_word_type w;
      rsp_word_type e;
      predictor_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(mk(CMD_TICK, 0, 0, 0, 0, 32'd0));
      directed.push_back(mk(CMD_SET_JOINT, 0, 32767, 0, 0, 32'd100));
      directed.push_back(mk(CMD_SET_JOINT, 0, -32768, 0, 0, 32'd105));
      directed.push_back(mk(CMD_SET_JOINT, 31, 0, 0, 0, 32'hFFFFFFFF));
      directed.push_back(mk(CMD_LOAD_HW, 1, 0, -4096, 4096, 32'd0));
      directed.push_back(mk(CMD_SET_JOINT, 1, 5000, 0, 0, 32'hFFFFFFF0));
      directed.push_back(mk(CMD_SET_JOINT, 1, -5000, 0, 0, 32'd3));
      directed.push_back(mk(CMD_SET_USER, 1, 0, -8000, 2000, 32'd0));
      directed.push_back(mk(CMD_SET_USER, 2, 0, 100, 100, 32'd0));
      directed.push_back(mk(CMD_SET_USER, 20, 0, -1, 1, 32'd0));
      directed.push_back(mk(CMD_SET_USER, 3, 0, -32768, 32767, 32'd0));
      directed.push_back(mk(CMD_LOAD_HW, 4, 0, 1000, -1000, 32'd0));
      directed.push_back(mk(CMD_SET_JOINT, 4, 20000, 0, 0, 32'd0));
      directed.push_back(mk(CMD_LOAD_HW, 25, 0, 0, 0, 32'd0));
      directed.push_back(mk(CMD_BAD_FIRST, 0, 0, 0, 0, 32'd0));
      directed.push_back(mk(CMD_BAD_LAST, 31, 0, 0, 0, 32'd0));
      directed.push_back(mk(CMD_TICK, 0, 0, 0, 0, 32'd0));
      directed.push_back(mk(CMD_RESET_USER, 31, 0, 0, 0, 32'd0));
      directed.push_back(mk(CMD_TICK, 0, 0, 0, 0, 32'd0));

      foreach (directed[i]) begin
         w = directed[i];
         send_word(w);
         // bad index and unknown command rows are known rejects
         if (known_reject(w)) begin
            e = expected_words[expected_words.size() - 1];
            if (e.rejected !== 1'b1) begin
               errors++;
               $display("%0t predictor: expected rejected 1, actual %b", $time, e.rejected);
            end
         end
      end

      drain();
      csr_set(CSR_ALPHA, 16'hFFFF);
      csr_set(CSR_MIN_INTERVAL, 16'd0);
      for (int i = 0; i < 60; i++) send_word(random_word());
      drain();
      csr_set(CSR_ALPHA, 16'd0);
      csr_set(CSR_MIN_INTERVAL, 16'd1000);
      for (int i = 0; i < 40; i++) send_word(random_word());
      drain();
      csr_set(CSR_ALPHA, 16'($urandom_range(1000, 40000)));
      csr_set(CSR_MIN_INTERVAL, 16'($urandom_range(1, 999)));
      for (int i = 0; i < 110; i++) send_word(random_word());

      drain();
      if (errors == 0 && expected_words.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule

[joint_command_limiter_smoother_unit.f]
rtl/core/jcls_pkg.sv
rtl/core/jcls_ctrl.sv
rtl/core/jcls_dp.sv
rtl/core/joint_command_limiter_smoother_unit.sv
test/testbench.sv
